### hdl/kc_pkg.sv
`timescale 1ns / 1ps

package kc_pkg;

    localparam int PRICE_W    = 32;
    localparam int ALPHA_W    = 17;
    localparam int MULT_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd8738;
    localparam logic [MULT_W-1:0]  MULT_RESET  = 16'd512;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EMA_ALPHA     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_MULTIPLE = 1'b1;

    // operand pair fed to the shared multiplier
    typedef enum logic [1:0] {
        MUL_CLOSE,
        MUL_RANGE,
        MUL_BAND
    } t_mul_sel;

    typedef struct packed {
        logic     load_in;
        logic     prep;
        logic     seed;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     upd_close;
        logic     upd_range;
        logic     load_out;
    } t_cmd;

    typedef struct packed {
        logic seed_needed;
    } t_status;

endpackage

### hdl/kc_if.sv
`timescale 1ns / 1ps

interface kc_bar_if;
    logic                                valid;
    logic                                ready;
    logic signed [kc_pkg::PRICE_W-1:0]   high_price;
    logic signed [kc_pkg::PRICE_W-1:0]   low_price;
    logic signed [kc_pkg::PRICE_W-1:0]   close_price;
    logic                                start_series;

    modport source (output valid, high_price, low_price, close_price, start_series,
                    input ready);
    modport sink   (input valid, high_price, low_price, close_price, start_series,
                    output ready);
endinterface

interface kc_band_if;
    logic                                valid;
    logic                                ready;
    logic signed [kc_pkg::PRICE_W-1:0]   lower_band;
    logic signed [kc_pkg::PRICE_W-1:0]   middle_band;
    logic signed [kc_pkg::PRICE_W-1:0]   upper_band;

    modport source (output valid, lower_band, middle_band, upper_band, input ready);
    modport sink   (input valid, lower_band, middle_band, upper_band, output ready);
endinterface

interface kc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [kc_pkg::CFG_IDX_W-1:0]      index;
    logic [kc_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/keltner_channel_ema_atr_core.sv
`timescale 1ns / 1ps
// channel   dir  beat contents
// i_bar     in   high_price, low_price, close_price (Q16.16), start_series
// o_band    out  lower_band, middle_band, upper_band (Q16.16, saturated)
// i_cfg     in   index (0 ema_alpha, 1 band_multiple), data
//
// a bar is taken only when the block is idle; an update bar steps through prep,
// close mul, range mul, range update, band mul and load, a seeding bar through
// prep, band mul and load; one shared 33x18 multiplier: close ema, range ema, band
// i_rst_n is synchronous: alpha and multiple go to their defaults, averages clear
// a result stalled at o_band holds in the output register; the next bar is
// still taken and waits only at its final step if the old beat is not gone
// configuration is always ready

module keltner_channel_ema_atr_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kc_bar_if.sink     i_bar,
    kc_band_if.source  o_band,
    kc_cfg_if.sink     i_cfg
);

    kc_pkg::t_cmd    w_cmd;     // controller to datapath
    kc_pkg::t_status w_status;  // datapath to controller

    // config writes land straight in the datapath registers
    assign i_cfg.ready = 1'b1;

    kc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_bar.valid),
        .o_in_ready  (i_bar.ready),
        .o_out_valid (o_band.valid),
        .i_out_ready (o_band.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // averages, true range, shared multiplier, band clamp
    kc_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_high     (i_bar.high_price),
        .i_low      (i_bar.low_price),
        .i_close    (i_bar.close_price),
        .i_start    (i_bar.start_series),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_idx  (i_cfg.index),
        .i_cfg_data (i_cfg.data),
        .o_lower    (o_band.lower_band),
        .o_middle   (o_band.middle_band),
        .o_upper    (o_band.upper_band)
    );

endmodule

### hdl/kc_ctrl.sv
`timescale 1ns / 1ps

module kc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  kc_pkg::t_status i_status,
    output kc_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL_CLOSE,
        S_MUL_RANGE,
        S_UPD_RANGE,
        S_MUL_BAND,
        S_BAND
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.mul_sel = kc_pkg::MUL_CLOSE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                o_cmd.seed = i_status.seed_needed;
                n_state    = i_status.seed_needed ? S_MUL_BAND : S_MUL_CLOSE;
            end
            S_MUL_CLOSE: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = kc_pkg::MUL_CLOSE;
                n_state       = S_MUL_RANGE;
            end
            S_MUL_RANGE: begin
                o_cmd.upd_close = 1'b1;
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_sel   = kc_pkg::MUL_RANGE;
                n_state         = S_UPD_RANGE;
            end
            S_UPD_RANGE: begin
                o_cmd.upd_range = 1'b1;
                n_state         = S_MUL_BAND;
            end
            S_MUL_BAND: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = kc_pkg::MUL_BAND;
                n_state       = S_BAND;
            end
            S_BAND: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### hdl/kc_dpath.sv
`timescale 1ns / 1ps

module kc_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  kc_pkg::t_cmd                        i_cmd,
    output kc_pkg::t_status                     o_status,
    input  logic signed [kc_pkg::PRICE_W-1:0]   i_high,
    input  logic signed [kc_pkg::PRICE_W-1:0]   i_low,
    input  logic signed [kc_pkg::PRICE_W-1:0]   i_close,
    input  logic                                i_start,
    input  logic                                i_cfg_we,
    input  logic [kc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [kc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic signed [kc_pkg::PRICE_W-1:0]   o_lower,
    output logic signed [kc_pkg::PRICE_W-1:0]   o_middle,
    output logic signed [kc_pkg::PRICE_W-1:0]   o_upper
);

    localparam int PW    = kc_pkg::PRICE_W;
    localparam int MA_W  = PW + 1;                     // multiplier a operand
    localparam int MB_W  = kc_pkg::ALPHA_W + 1;        // multiplier b operand
    localparam int PR_W  = MA_W + MB_W;                // product
    localparam int SAT_W = PW + 12;                    // widest sum before clamp

    function automatic logic signed [PW-1:0] sat(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi_lim;
        logic signed [SAT_W-1:0] lo_lim;
        hi_lim = SAT_W'({1'b0, {(PW-1){1'b1}}});
        lo_lim = -hi_lim - SAT_W'(1);
        if (v > hi_lim)      sat = {1'b0, {(PW-1){1'b1}}};
        else if (v < lo_lim) sat = {1'b1, {(PW-1){1'b0}}};
        else                 sat = v[PW-1:0];
    endfunction

    logic [kc_pkg::ALPHA_W-1:0] r_alpha;
    logic [kc_pkg::MULT_W-1:0]  r_mult;
    logic                       r_seeded;
    logic signed [PW-1:0]       r_close_avg, r_range_avg, r_last_close;
    logic signed [PW-1:0]       r_high, r_low, r_close, r_tr;
    logic                       r_start;
    logic signed [PR_W-1:0]     r_prod;
    logic signed [PW-1:0]       r_lower, r_middle, r_upper;

    logic signed [PW-1:0]       w_top, w_bot, w_tr, w_seed_range;
    logic signed [MA_W-1:0]     w_mul_a;
    logic signed [MB_W-1:0]     w_mul_b;
    logic signed [PR_W-1:0]     w_prod, w_ema_rnd, w_band_rnd;
    logic signed [PR_W-17:0]    w_inc;
    logic signed [PR_W-9:0]     w_offset;
    logic signed [PW-1:0]       w_ema_new, w_upper, w_lower;

    assign o_status.seed_needed = r_start || !r_seeded;

    // true range against the previous close, and the seeding range
    assign w_top = (r_high > r_last_close) ? r_high : r_last_close;
    assign w_bot = (r_low < r_last_close) ? r_low : r_last_close;
    assign w_tr  = sat(SAT_W'(MA_W'(w_top) - MA_W'(w_bot)));
    assign w_seed_range = sat(SAT_W'(MA_W'(r_high) - MA_W'(r_low)));

    // shared multiplier operand select
    always_comb begin
        case (i_cmd.mul_sel)
            kc_pkg::MUL_CLOSE: begin
                w_mul_a = MA_W'(r_close) - MA_W'(r_close_avg);
                w_mul_b = MB_W'(r_alpha);
            end
            kc_pkg::MUL_RANGE: begin
                w_mul_a = MA_W'(r_tr) - MA_W'(r_range_avg);
                w_mul_b = MB_W'(r_alpha);
            end
            kc_pkg::MUL_BAND: begin
                w_mul_a = MA_W'(r_range_avg);
                w_mul_b = MB_W'(r_mult);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = PR_W'(w_mul_a) * PR_W'(w_mul_b);

    // ema increment, round half up then floor
    assign w_ema_rnd = r_prod + PR_W'(32768);
    assign w_inc     = $signed(w_ema_rnd[PR_W-1:16]);
    assign w_ema_new = sat(SAT_W'(i_cmd.upd_close ? r_close_avg : r_range_avg)
                           + SAT_W'(w_inc));

    // band offset in Q16.16
    assign w_band_rnd = r_prod + PR_W'(128);
    assign w_offset   = $signed(w_band_rnd[PR_W-1:8]);
    assign w_upper    = sat(SAT_W'(r_close_avg) + SAT_W'(w_offset));
    assign w_lower    = sat(SAT_W'(r_close_avg) - SAT_W'(w_offset));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha      <= kc_pkg::ALPHA_RESET;
            r_mult       <= kc_pkg::MULT_RESET;
            r_seeded     <= 1'b0;
            r_close_avg  <= '0;
            r_range_avg  <= '0;
            r_last_close <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    kc_pkg::REG_EMA_ALPHA:     r_alpha <= i_cfg_data;
                    kc_pkg::REG_BAND_MULTIPLE: r_mult  <= i_cfg_data[kc_pkg::MULT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.prep) begin
                r_last_close <= r_close;
            end
            if (i_cmd.seed) begin
                r_seeded    <= 1'b1;
                r_close_avg <= r_close;
                r_range_avg <= w_seed_range;
            end
            if (i_cmd.upd_close) begin
                r_close_avg <= w_ema_new;
            end
            if (i_cmd.upd_range) begin
                r_range_avg <= w_ema_new;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_high  <= i_high;
            r_low   <= i_low;
            r_close <= i_close;
            r_start <= i_start;
        end
        if (i_cmd.prep) begin
            r_tr <= w_tr;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_cmd.load_out) begin
            r_lower  <= w_lower;
            r_middle <= r_close_avg;
            r_upper  <= w_upper;
        end
    end

    assign o_lower  = r_lower;
    assign o_middle = r_middle;
    assign o_upper  = r_upper;

endmodule

### hdl/kc_checker.sv
`timescale 1ns / 1ps

module kc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [kc_pkg::PRICE_W-1:0]        i_middle
);

    // a result beat stays up until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // stalled result payload does not move
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_middle))
        else $error("result payload changed while stalled");

    // one bar at a time: a taken bar closes the input
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after a bar was taken");

    // no result can be pending straight after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind keltner_channel_ema_atr_core kc_checker u_kc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_bar.valid),
    .i_in_ready  (i_bar.ready),
    .i_out_valid (o_band.valid),
    .i_out_ready (o_band.ready),
    .i_middle    (o_band.middle_band)
);
